>>> design/ofdm_bit_interleaver_assert.svh
// Assertion macros for the OFDM bit interleaver.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef OFDM_BIT_INTERLEAVER_ASSERT_SVH
`define OFDM_BIT_INTERLEAVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OBI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("obi: same-cycle check failed");

// next-cycle implication, disabled during reset
`define OBI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("obi: next-cycle check failed");

`endif

>>> design/obi_pkg.sv
// Shared types, constants and helper functions of the OFDM bit interleaver.
// No dependencies; used by the interfaces, the address unit and the top level.
`default_nettype none

package obi_pkg;

   // fixed geometry
   localparam int MAX_SYMBOL_BITS_DEF = 288;
   localparam int SYMBOL_QUANTUM      = 48;
   localparam int COLUMNS             = 16;
   localparam int COL_W               = 4;
   localparam int BYTE_BITS           = 8;
   localparam int Q_W                 = 3;   // symbol size in units of 48 bits, 1..6

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] REG_CODED_BITS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BITS_PER_SC = 1'b1;

   // rotation group sizes
   localparam logic [1:0] GRP_ONE   = 2'd1;
   localparam logic [1:0] GRP_TWO   = 2'd2;
   localparam logic [1:0] GRP_THREE = 2'd3;

   // permutation setup handed to the address unit
   typedef struct packed {
      logic [Q_W-1:0] q;       // N / 48
      logic [1:0]     group;   // rotation group size
   } perm_cfg_type;

   localparam perm_cfg_type CFG_RESET = '{q: Q_W'(1), group: GRP_ONE};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_EMIT
   } state_type;

   // value mod 3 by weighted bit sum (2^n mod 3 alternates 1, 2)
   function automatic logic [1:0] mod3(input logic [7:0] v);
      logic [2:0] acc;
      acc = 3'd0;
      for (int n = 0; n < 8; n++) begin
         if (v[n]) begin
            acc = acc + (((n & 1) == 0) ? 3'd1 : 3'd2);
         end
         if (acc >= 3'd3) begin
            acc = acc - 3'd3;
         end
      end
      return acc[1:0];
   endfunction

endpackage

`default_nettype wire

>>> design/obi_req_if.sv
// Input channel of the OFDM bit interleaver: one coded byte per transaction.
// Depends on obi_pkg for the byte width.
`default_nettype none

interface obi_req_if;
   logic                           valid;
   logic                           ready;
   logic [obi_pkg::BYTE_BITS-1:0]  data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

>>> design/obi_rsp_if.sv
// Result channel of the OFDM bit interleaver: one interleaved byte per transaction.
// Depends on obi_pkg for the byte width.
`default_nettype none

interface obi_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [obi_pkg::BYTE_BITS-1:0]  out_byte;
   logic                           last_of_symbol;

   modport source (output valid, output out_byte, output last_of_symbol, input ready);
   modport sink   (input valid, input out_byte, input last_of_symbol, output ready);
endinterface

`default_nettype wire

>>> design/obi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module obi_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> design/obi_addr_unit.sv
// Bit address unit: maps input bit index k to its interleaved store address.
// Depends on obi_pkg for the permutation setup type and the mod-3 helper.
`default_nettype none

module obi_addr_unit #(
   parameter int MAX_SYMBOL_BITS = obi_pkg::MAX_SYMBOL_BITS_DEF,
   localparam int AW             = $clog2(MAX_SYMBOL_BITS)
) (
   input  wire obi_pkg::perm_cfg_type cfg,
   input  wire logic [AW-1:0]         k,
   output logic      [AW-1:0]         j
);

   localparam int RW = AW - obi_pkg::COL_W;

   logic [obi_pkg::COL_W-1:0]            col;
   logic [RW-1:0]                        row;
   logic [obi_pkg::Q_W+obi_pkg::COL_W-1:0] qc;
   logic [obi_pkg::Q_W+obi_pkg::COL_W+1:0] qc3;
   logic [AW-1:0]                        i_addr;
   logic [1:0]                           rm;
   logic [1:0]                           cm;
   logic [1:0]                           dm;

   // first permutation: i = (N/16) * (k mod 16) + k / 16, with N/16 = 3q
   assign col    = k[obi_pkg::COL_W-1:0];
   assign row    = k[AW-1:obi_pkg::COL_W];
   assign qc     = cfg.q * col;
   assign qc3    = {1'b0, qc, 1'b0} + {2'b00, qc};
   assign i_addr = AW'(qc3) + AW'(row);

   // floor(16i/N) equals the column, and N is a multiple of the group size,
   // so the rotation term reduces to (i - col) mod s; i mod 3 equals row mod 3
   assign rm = obi_pkg::mod3(8'(row));
   assign cm = obi_pkg::mod3(8'(col));
   assign dm = (rm >= cm) ? (rm - cm) : (rm + 2'd3 - cm);

   // second permutation
   always_comb begin
      unique case (cfg.group)
         obi_pkg::GRP_TWO:   j = {i_addr[AW-1:1], i_addr[0] ^ col[0]};
         obi_pkg::GRP_THREE: j = i_addr - AW'(rm) + AW'(dm);
         default:            j = i_addr;
      endcase
   end

endmodule

`default_nettype wire

>>> design/ofdm_bit_interleaver.sv
// Top level of the OFDM bit interleaver: sequencer, symbol store and output register.
// Depends on obi_pkg, obi_req_if, obi_rsp_if, obi_ram, obi_addr_unit and the assert header.
//
// Coded bits enter as bytes, first bit in the MSB, and are written one bit per
// cycle into a 1-bit-wide symbol store at the address given by the two
// interleaver permutations; the address unit is shared by all eight bits of a
// byte. An input byte is accepted in the idle state and then written bit by
// bit in the write state; no new byte is taken until the block is idle again.
// The byte that completes a symbol of N bits is followed by the read-out: each
// of the N/8 result bytes is gathered by single-bit reads through the store's
// one read port, whose registered data is shifted into a byte, and is loaded into
// the output register once the result side is free. The output register lets
// the next input byte be taken while the last result byte is still waiting.
// The store needs no clearing after reset. A configuration write drops any
// partial symbol; writes are meant to happen only while the block is idle.
`default_nettype none

`include "ofdm_bit_interleaver_assert.svh"

module ofdm_bit_interleaver #(
   parameter int MAX_SYMBOL_BITS = obi_pkg::MAX_SYMBOL_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   obi_req_if.sink                             req_bus,
   obi_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [obi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [obi_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW   = $clog2(MAX_SYMBOL_BITS);
   localparam int QMAX = MAX_SYMBOL_BITS / obi_pkg::SYMBOL_QUANTUM;
   localparam int NBW  = $clog2(MAX_SYMBOL_BITS / obi_pkg::BYTE_BITS + 1);

   obi_pkg::state_type    state_ff, state_in;
   obi_pkg::perm_cfg_type cfg_ff, cfg_in;
   logic [NBW-1:0]        bytes_ff, bytes_in;
   logic [NBW-1:0]        m_ff, m_in;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            byte_ff, byte_in;
   logic [7:0]            sh_ff, sh_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  out_load;
   logic                  sym_done;
   logic                  emit_last;
   logic [NBW-1:0]        nbytes;
   logic [AW-1:0]         wr_k;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic                  ram_we;
   logic [0:0]            ram_rdata;
   logic [obi_pkg::Q_W-1:0] q_new;
   logic [1:0]            group_new;

   // handshake and status terms
   assign req_accept = req_bus.valid && req_bus.ready;
   assign out_free   = !out_valid_ff || rsp_bus.ready;
   assign nbytes     = NBW'(6 * cfg_ff.q);
   assign sym_done   = (NBW'(bytes_ff + 1'b1) == nbytes);
   assign emit_last  = (NBW'(m_ff + 1'b1) == nbytes);
   assign out_load   = (state_ff == obi_pkg::ST_EMIT) && !rd_pend_ff && out_free;

   // shared address unit and symbol store
   assign wr_k    = AW'({bytes_ff, bit_ff});
   assign rd_addr = AW'({m_ff, bit_ff});
   assign ram_we  = (state_ff == obi_pkg::ST_WRITE);

   obi_addr_unit #(
      .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
   ) u_addr (
      .cfg (cfg_ff),
      .k   (wr_k),
      .j   (wr_addr)
   );

   obi_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SYMBOL_BITS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (byte_ff[7]),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // effective register values for a configuration write
   always_comb begin
      q_new = obi_pkg::Q_W'(1);
      for (int m = 1; m <= QMAX; m++) begin
         if ({1'b0, csr_wdata} >= 10'(obi_pkg::SYMBOL_QUANTUM * m)) begin
            q_new = obi_pkg::Q_W'(m);
         end
      end
      group_new = (csr_wdata[2:1] == 2'd0) ? obi_pkg::GRP_ONE : csr_wdata[2:1];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         obi_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = obi_pkg::ST_WRITE;
            end
         end
         obi_pkg::ST_WRITE: begin
            if (bit_ff == 3'd7) begin
               state_in = sym_done ? obi_pkg::ST_READ : obi_pkg::ST_IDLE;
            end
         end
         obi_pkg::ST_READ: begin
            if (bit_ff == 3'd7) begin
               state_in = obi_pkg::ST_EMIT;
            end
         end
         obi_pkg::ST_EMIT: begin
            if (out_load) begin
               state_in = emit_last ? obi_pkg::ST_IDLE : obi_pkg::ST_READ;
            end
         end
      endcase
   end

   // datapath and counters
   always_comb begin
      cfg_in       = cfg_ff;
      bytes_in     = bytes_ff;
      m_in         = m_ff;
      bit_in       = bit_ff;
      byte_in      = byte_ff;
      rd_pend_in   = (state_ff == obi_pkg::ST_READ);
      sh_in        = rd_pend_ff ? {sh_ff[6:0], ram_rdata[0]} : sh_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         obi_pkg::ST_IDLE: begin
            if (req_accept) begin
               byte_in = req_bus.data_byte;
               bit_in  = 3'd0;
            end
         end
         obi_pkg::ST_WRITE: begin
            byte_in = {byte_ff[6:0], 1'b0};
            bit_in  = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               if (sym_done) begin
                  bytes_in = '0;
                  m_in     = '0;
               end else begin
                  bytes_in = NBW'(bytes_ff + 1'b1);
               end
            end
         end
         obi_pkg::ST_READ: begin
            bit_in = bit_ff + 3'd1;
         end
         obi_pkg::ST_EMIT: begin
            if (out_load) begin
               m_in = NBW'(m_ff + 1'b1);
            end
         end
      endcase

      // output register
      if (out_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = sh_ff;
         out_last_in  = emit_last;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      // configuration write drops the partial symbol
      if (csr_we) begin
         bytes_in = '0;
         unique case (csr_index)
            obi_pkg::REG_CODED_BITS:  cfg_in.q     = q_new;
            obi_pkg::REG_BITS_PER_SC: cfg_in.group = group_new;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= obi_pkg::ST_IDLE;
         cfg_ff       <= obi_pkg::CFG_RESET;
         bytes_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         bytes_ff     <= bytes_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      bit_ff      <= bit_in;
      byte_ff     <= byte_in;
      sh_ff       <= sh_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // ports
   assign req_bus.ready          = (state_ff == obi_pkg::ST_IDLE);
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.out_byte       = out_byte_ff;
   assign rsp_bus.last_of_symbol = out_last_ff;

   // checks
   `OBI_ASSERT_NXT(a_accept_starts_write, clock, reset, req_accept, (state_ff == obi_pkg::ST_WRITE) && (bit_ff == 3'd0))
   `OBI_ASSERT_IMP(a_read_in_range, clock, reset, state_ff == obi_pkg::ST_READ, m_ff < nbytes)
   `OBI_ASSERT_NXT(a_last_ends_symbol, clock, reset, out_load && emit_last, (state_ff == obi_pkg::ST_IDLE) && (bytes_ff == '0) && out_last_ff)
   `OBI_ASSERT_IMP(a_pend_while_reading, clock, reset, rd_pend_ff, (state_ff == obi_pkg::ST_READ) || (state_ff == obi_pkg::ST_EMIT))

endmodule

`default_nettype wire
